>>> hdl/sharded_scatter_write_address_gen_unit_defines.svh
// Assertion macros used by the file that checks this block.
// Each expects clk_i and rst_ni in scope.
`ifndef SHARDED_SCATTER_WRITE_ADDRESS_GEN_UNIT_DEFINES_SVH
`define SHARDED_SCATTER_WRITE_ADDRESS_GEN_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SSWAG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SSWAG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sswag_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sswag_pkg;

  localparam int NumChannelsDef = 8;
  localparam int MaxCoresDef    = 64;
  localparam int SegLimit       = 64;

  typedef enum logic {
    CMD_BEGIN = 1'b0,
    CMD_CHUNK = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_WIDTH_SHARD_MODE      = 3'd0,
    CFG_BLOCK_SIZE            = 3'd1,
    CFG_ROWS_PER_CORE         = 3'd2,
    CFG_ROW_GAP               = 3'd3,
    CFG_FIRST_BLOCK_REMAINING = 3'd4,
    CFG_START_SHARD_OFFSET    = 3'd5,
    CFG_BASE_ADDRESS          = 3'd6,
    CFG_WRAP_STEP             = 3'd7
  } cfg_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] byte_count;
    logic        end_of_transfer;
    logic [5:0]  start_core;
    logic [11:0] start_row;
    logic [7:0]  start_ring;
    logic [7:0]  ring_count;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  core_index;
    logic [31:0] dest_offset;
    logic [15:0] segment_bytes;
    logic [2:0]  channel;
    logic [15:0] source_offset;
    logic        last;
    logic        core_overflow;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_begin;
    logic load_chunk;
    logic seg_step;
    logic finish;
    logic restart;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic rem_zero;
    logic seg_last;
    logic out_free;
    logic eot;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> hdl/sswag_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sswag_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/sharded_scatter_write_address_gen_unit.sv
// Scatter write address generator for sharded destination buffers.
// Input channel item_in_i carries begin items (load start core, row, ring
// index and ring reload, and take the base from base_address) and chunk
// items (byte count and end-of-transfer flag). Each chunk is split into
// write segments, one result item on result_out_o per segment, at most 64
// per chunk; the last segment carries last = 1.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i;
// the user must write it only while idle, as the block does not enforce it.
// A chunk is accepted, takes one segment step per segment and a finish
// step, plus a restart step with end of transfer; an empty chunk takes
// no segment step, and a begin item only the accept and a restart step.
// While the output is free, one segment per cycle goes from the segment
// loop into a single output register, visible the cycle after it is made.
// A stalled receiver holds the output register and pauses the segment
// loop; a new input item is still accepted while the final result waits.
// Reset is asynchronous and active low; it clears all position state and
// returns the configuration registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "sharded_scatter_write_address_gen_unit_defines.svh"

module sharded_scatter_write_address_gen_unit #(
  parameter int RX_CHANNELS = sswag_pkg::NumChannelsDef,
  parameter int MAX_CORES   = sswag_pkg::MaxCoresDef
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    cfg_we_i,
  input  wire  [2:0]             cfg_index_i,
  input  wire  [31:0]            cfg_data_i,
  sswag_stream_if.sink           item_in_i,
  sswag_stream_if.source         result_out_o
);

  localparam int LastCoreInt = (MAX_CORES >= 64) ? 63 : (MAX_CORES - 1);
  localparam logic [5:0] LastCore = 6'(LastCoreInt);

  sswag_pkg::dp_cmd_t   dp_cmd;
  sswag_pkg::dp_stat_t  dp_stat;
  sswag_pkg::in_item_t  in_data;
  sswag_pkg::out_item_t out_data;
  logic                 in_ready;
  logic                 out_valid;

  assign in_data            = item_in_i.data;
  assign item_in_i.ready    = in_ready;
  assign result_out_o.valid = out_valid;
  assign result_out_o.data  = out_data;

  sswag_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_in_i.valid),
    .in_cmd_i   (in_data.cmd),
    .in_ready_o (in_ready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  sswag_dp #(
    .RX_CHANNELS (RX_CHANNELS),
    .MAX_CORES   (MAX_CORES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (sswag_pkg::cfg_e'(cfg_index_i)),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .out_valid_o (out_valid),
    .out_ready_i (result_out_o.ready),
    .out_data_o  (out_data)
  );

  `SSWAG_ASSERT_IMP(a_no_seg_while_idle, in_ready, !dp_cmd.seg_step, "segment while idle")
  `SSWAG_ASSERT_NXT(a_last_ends_loop, dp_cmd.seg_step && dp_stat.seg_last, !dp_cmd.seg_step, "segment after last")
  `SSWAG_ASSERT_IMP(a_ovf_at_last_core, out_valid && out_data.core_overflow, out_data.core_index == LastCore, "overflow off last core")
  `SSWAG_ASSERT_IMP(a_seg_nonzero, out_valid, out_data.segment_bytes != 16'd0, "empty segment")

endmodule

`default_nettype wire

>>> hdl/sswag_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sswag_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  sswag_pkg::cmd_e     in_cmd_i,
  output logic                in_ready_o,
  input  sswag_pkg::dp_stat_t stat_i,
  output sswag_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEG,
    ST_FINISH,
    ST_RESTART
  } state_e;

  state_e state_q;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load_begin = accept && (in_cmd_i == sswag_pkg::CMD_BEGIN);
        cmd_o.load_chunk = accept && (in_cmd_i == sswag_pkg::CMD_CHUNK);
      end
      ST_SEG: begin
        cmd_o.seg_step = !stat_i.rem_zero && stat_i.out_free;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
      end
      ST_RESTART: begin
        cmd_o.restart = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= (in_cmd_i == sswag_pkg::CMD_BEGIN) ? ST_RESTART : ST_SEG;
          end
        end
        ST_SEG: begin
          // An empty chunk skips straight to the channel and ring update.
          if (stat_i.rem_zero) begin
            state_q <= ST_FINISH;
          end else if (stat_i.out_free && stat_i.seg_last) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          state_q <= stat_i.eot ? ST_RESTART : ST_IDLE;
        end
        ST_RESTART: begin
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/sswag_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module sswag_dp #(
  parameter int RX_CHANNELS = sswag_pkg::NumChannelsDef,
  parameter int MAX_CORES   = sswag_pkg::MaxCoresDef
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  sswag_pkg::cfg_e      cfg_index_i,
  input  wire  [31:0]          cfg_data_i,
  input  sswag_pkg::in_item_t  in_data_i,
  input  sswag_pkg::dp_cmd_t   cmd_i,
  output sswag_pkg::dp_stat_t  stat_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output sswag_pkg::out_item_t out_data_o
);

  localparam int ChW         = (RX_CHANNELS > 1) ? $clog2(RX_CHANNELS) : 1;
  localparam int LastCoreInt = (MAX_CORES >= 64) ? 63 : (MAX_CORES - 1);
  localparam logic [5:0] LastCore = 6'(LastCoreInt);
  localparam logic [5:0] LastSeg  = 6'(sswag_pkg::SegLimit - 1);
  localparam logic [ChW-1:0] LastCh = ChW'(RX_CHANNELS - 1);

  // Configuration registers.
  logic        wsm_q;
  logic [15:0] block_size_q;
  logic [11:0] rows_q;
  logic [15:0] row_gap_q;
  logic [15:0] fbr_q;
  logic [31:0] sso_q;
  logic [31:0] base_addr_q;
  logic [31:0] wrap_q;

  // Position state.
  logic [5:0]     core_q;
  logic [11:0]    row_q;
  logic [31:0]    woff_q;
  logic [15:0]    bleft_q;
  logic [31:0]    base_q;
  logic [7:0]     ring_q;
  logic [7:0]     reload_q;
  logic [5:0]     core_start_q;
  logic [11:0]    row_start_q;
  logic [ChW-1:0] ch_q;

  // Per-chunk state.
  logic [15:0] rem_q;
  logic [15:0] src_q;
  logic [5:0]  nseg_q;
  logic        eot_q;
  logic        out_valid_q;

  // Segment arithmetic.
  logic [15:0]    bs_nz;
  logic [15:0]    fbr_nz;
  logic [15:0]    left;
  logic           fits;
  logic [15:0]    seg;
  logic [15:0]    rem_after;
  logic           seg_last;
  logic           core_at_end;
  logic [5:0]     core_adv;
  logic [11:0]    row_inc;
  logic           row_hit;
  logic [5:0]     core_nxt;
  logic [11:0]    row_nxt;
  logic [31:0]    woff_nxt;
  logic           ovf;
  logic [5:0]     core_clamped;
  logic [ChW+2:0] ch_wide;

  assign bs_nz     = (block_size_q == 16'd0) ? 16'd1 : block_size_q;
  assign fbr_nz    = (fbr_q == 16'd0) ? 16'd1 : fbr_q;
  assign left      = (bleft_q != 16'd0) ? bleft_q : bs_nz;
  assign fits      = left > rem_q;
  assign seg       = fits ? rem_q : left;
  assign rem_after = rem_q - seg;
  assign seg_last  = (rem_after == 16'd0) || (nseg_q == LastSeg);

  assign core_at_end  = core_q >= LastCore;
  assign core_adv     = core_at_end ? LastCore : core_q + 6'd1;
  assign row_inc      = row_q + 12'd1;
  assign row_hit      = row_inc == rows_q;
  assign core_clamped = (core_start_q > LastCore) ? LastCore : core_start_q;
  assign ch_wide      = (ChW + 3)'(ch_q);

  always_comb begin
    core_nxt = core_q;
    row_nxt  = row_q;
    woff_nxt = woff_q;
    ovf      = 1'b0;
    if (fits) begin
      woff_nxt = woff_q + 32'(rem_q);
    end else if (wsm_q && !row_hit) begin
      row_nxt  = row_inc;
      woff_nxt = woff_q + 32'(left) + 32'(row_gap_q);
    end else begin
      // The block is full and the core moves on, saturating at the last core.
      if (wsm_q) begin
        row_nxt = 12'd0;
      end
      core_nxt = core_adv;
      ovf      = core_at_end;
      woff_nxt = base_q;
    end
  end

  assign stat_o.rem_zero = (rem_q == 16'd0);
  assign stat_o.seg_last = seg_last;
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign stat_o.eot      = eot_q;

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsm_q        <= 1'b0;
      block_size_q <= 16'd32;
      rows_q       <= 12'd1;
      row_gap_q    <= 16'd0;
      fbr_q        <= 16'd32;
      sso_q        <= 32'd0;
      base_addr_q  <= 32'd0;
      wrap_q       <= 32'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sswag_pkg::CFG_WIDTH_SHARD_MODE:      wsm_q        <= cfg_data_i[0];
        sswag_pkg::CFG_BLOCK_SIZE:            block_size_q <= cfg_data_i[15:0];
        sswag_pkg::CFG_ROWS_PER_CORE:         rows_q       <= cfg_data_i[11:0];
        sswag_pkg::CFG_ROW_GAP:               row_gap_q    <= cfg_data_i[15:0];
        sswag_pkg::CFG_FIRST_BLOCK_REMAINING: fbr_q        <= cfg_data_i[15:0];
        sswag_pkg::CFG_START_SHARD_OFFSET:    sso_q        <= cfg_data_i;
        sswag_pkg::CFG_BASE_ADDRESS:          base_addr_q  <= cfg_data_i;
        sswag_pkg::CFG_WRAP_STEP:             wrap_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_q       <= '0;
      row_q        <= '0;
      woff_q       <= '0;
      bleft_q      <= '0;
      base_q       <= '0;
      ring_q       <= '0;
      reload_q     <= '0;
      core_start_q <= '0;
      row_start_q  <= '0;
      ch_q         <= '0;
      rem_q        <= '0;
      src_q        <= '0;
      nseg_q       <= '0;
      eot_q        <= 1'b0;
    end else begin
      if (cmd_i.load_begin) begin
        core_start_q <= in_data_i.start_core;
        row_start_q  <= in_data_i.start_row;
        ring_q       <= in_data_i.start_ring;
        reload_q     <= in_data_i.ring_count;
        base_q       <= base_addr_q;
        ch_q         <= '0;
        eot_q        <= 1'b0;
      end
      if (cmd_i.load_chunk) begin
        rem_q  <= in_data_i.byte_count;
        src_q  <= 16'd0;
        nseg_q <= 6'd0;
        eot_q  <= in_data_i.end_of_transfer;
      end
      if (cmd_i.seg_step) begin
        core_q  <= core_nxt;
        row_q   <= row_nxt;
        woff_q  <= woff_nxt;
        bleft_q <= fits ? (left - rem_q) : bs_nz;
        // Bytes beyond the segment limit are dropped with the chunk.
        rem_q   <= seg_last ? 16'd0 : rem_after;
        src_q   <= src_q + seg;
        nseg_q  <= nseg_q + 6'd1;
      end
      if (cmd_i.finish) begin
        ch_q <= (ch_q == LastCh) ? '0 : ch_q + 1'b1;
        if (eot_q) begin
          if (ring_q == 8'd0) begin
            ring_q <= reload_q;
            base_q <= base_q + wrap_q;
          end else begin
            ring_q <= ring_q - 8'd1;
            base_q <= base_q - 32'(block_size_q);
          end
        end
      end
      if (cmd_i.restart) begin
        bleft_q <= fbr_nz;
        woff_q  <= sso_q + base_q;
        row_q   <= row_start_q;
        core_q  <= core_clamped;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.seg_step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.seg_step) begin
      out_data_o.core_index    <= core_q;
      out_data_o.dest_offset   <= woff_q;
      out_data_o.segment_bytes <= seg;
      out_data_o.channel       <= ch_wide[2:0];
      out_data_o.source_offset <= src_q;
      out_data_o.last          <= seg_last;
      out_data_o.core_overflow <= ovf;
    end
  end

endmodule

`default_nettype wire
